// File: rtl/infix_to_postfix_converter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the infix to postfix converter
// Assertions are checked on the rising clock edge and are off while the block is in reset.
// Defining NO_ASSERTIONS removes them all.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge outside reset.
`define ITP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// When the condition holds, the consequence must hold at the next clock edge.
`define ITP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ITP_ASSERT(label, prop, msg)
`define ITP_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: rtl/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// Types, character codes and operator tables for the infix to postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam int ITP_STACK_DEPTH = 16;

    localparam logic [7:0] CH_LPAR = 8'h28;
    localparam logic [7:0] CH_RPAR = 8'h29;
    localparam logic [7:0] CH_NOT  = 8'h21;
    localparam logic [7:0] CH_AND  = 8'h26;
    localparam logic [7:0] CH_OR   = 8'h7C;

    typedef enum logic [1:0] {
        OP_LPAR,
        OP_NOT,
        OP_AND,
        OP_OR
    } t_op_code;

    typedef enum logic [2:0] {
        K_SKIP,
        K_ALNUM,
        K_OP,
        K_LPAR,
        K_RPAR
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT,
        S_FIN,
        S_FWAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [7:0] sym;
        logic       sym_valid;
        logic       err;
    } t_pend;

    typedef struct packed {
        logic [7:0] sym;
        logic       sym_valid;
        logic       run_last;
        logic       expr_end;
        logic       err;
    } t_result;

    function automatic t_kind classify(input logic [7:0] c);
        t_kind k;
        k = K_SKIP;
        if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
            (c >= 8'h61 && c <= 8'h7A)) begin
            k = K_ALNUM;
        end else if (c == CH_NOT || c == CH_AND || c == CH_OR) begin
            k = K_OP;
        end else if (c == CH_LPAR) begin
            k = K_LPAR;
        end else if (c == CH_RPAR) begin
            k = K_RPAR;
        end
        return k;
    endfunction

    function automatic t_op_code char_code(input logic [7:0] c);
        t_op_code code;
        code = OP_LPAR;
        if (c == CH_NOT) begin
            code = OP_NOT;
        end else if (c == CH_AND) begin
            code = OP_AND;
        end else if (c == CH_OR) begin
            code = OP_OR;
        end
        return code;
    endfunction

    function automatic logic [7:0] code_char(input t_op_code code);
        logic [7:0] c;
        unique case (code)
            OP_LPAR: c = CH_LPAR;
            OP_NOT:  c = CH_NOT;
            OP_AND:  c = CH_AND;
            OP_OR:   c = CH_OR;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] code_prec(input t_op_code code);
        logic [2:0] p;
        unique case (code)
            OP_LPAR: p = 3'd0;
            OP_NOT:  p = 3'd4;
            OP_AND:  p = 3'd5;
            OP_OR:   p = 3'd6;
        endcase
        return p;
    endfunction

    // An arriving operator pops the top when the top is an operator and the
    // arriving one binds looser, or equally loose while being left associative.
    function automatic logic must_pop(input t_op_code incoming, input t_op_code top);
        logic left;
        left = (incoming != OP_NOT);
        return (top != OP_LPAR) &&
               ((left && code_prec(incoming) >= code_prec(top)) ||
                (code_prec(incoming) > code_prec(top)));
    endfunction

endpackage

// File: rtl/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Boolean infix to postfix conversion with an operator stack in a memory.
//
// The input channel takes one ASCII character per beat, with a flag that
// marks the last character of an expression. The output channel gives one
// postfix character per beat, with flags for the last beat caused by an
// input, the end of the expression and a sticky error.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. The input is stalled while a character is being worked on.
// The block takes no new input beat before it has finished the last one.
// The stack memory has a registered read port, so each entry popped is
// read before it is emitted, and a '(' or operator that ends the search
// is read too. At the last character each entry left is read and flushed.
// Results go through a one-entry holding stage and a registered output.
// A stalled receiver holds up the block only when both stages are full.
// Synchronous reset empties the stack, clears the error and drops any
// result not yet delivered. Stack writes and reads never fall in the same
// cycle, so no forwarding is needed.
// ----------------------------------------------------------------------------
`include "infix_to_postfix_converter_assert.svh"

module infix_to_postfix_converter
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = ITP_STACK_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_symbol,
    input  logic       i_final_char,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_symbol,
    output logic       o_symbol_valid,
    output logic       o_run_last,
    output logic       o_expr_end,
    output logic       o_error_flag
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_err, n_err;
    logic            r_pv, n_pv;
    logic            r_ov, n_ov;
    t_kind           r_kind, n_kind;
    t_op_code        r_code, n_code;
    logic [7:0]      r_sym, n_sym;
    logic            r_fin, n_fin;
    t_pend           r_pnd, n_pnd;
    t_result         r_out, n_out;
    t_op_code        r_top;
    t_op_code        r_stack_mem [STACK_DEPTH];

    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [CW-1:0]   cnt_m1;
    logic            out_free, can_emit;
    logic            em_req, em_sv, do_push;
    logic [7:0]      em_sym;

    assign cnt_m1   = r_count - CW'(1);
    assign out_free = !r_ov || !i_out_stall;
    assign can_emit = !r_pv || out_free;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_err     = r_err;
        n_pv      = r_pv;
        n_ov      = r_ov;
        n_kind    = r_kind;
        n_code    = r_code;
        n_sym     = r_sym;
        n_fin     = r_fin;
        n_pnd     = r_pnd;
        n_out     = r_out;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = r_count[AW-1:0];
        mem_raddr = cnt_m1[AW-1:0];
        em_req    = 1'b0;
        em_sv     = 1'b0;
        em_sym    = '0;
        do_push   = 1'b0;

        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_sym   = i_symbol;
                    n_fin   = i_final_char;
                    n_kind  = classify(i_symbol);
                    n_code  = char_code(i_symbol);
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_kind)
                    K_ALNUM: begin
                        if (can_emit) begin
                            em_req  = 1'b1;
                            em_sym  = r_sym;
                            em_sv   = 1'b1;
                            n_state = S_FIN;
                        end
                    end
                    K_SKIP: begin
                        n_state = S_FIN;
                    end
                    K_LPAR: begin
                        do_push = 1'b1;
                        n_state = S_FIN;
                    end
                    K_OP: begin
                        if (r_count == '0) begin
                            do_push = 1'b1;
                            n_state = S_FIN;
                        end else begin
                            mem_re  = 1'b1;
                            n_state = S_WAIT;
                        end
                    end
                    K_RPAR: begin
                        if (r_count == '0) begin
                            n_err   = 1'b1;
                            n_state = S_FIN;
                        end else begin
                            mem_re  = 1'b1;
                            n_state = S_WAIT;
                        end
                    end
                endcase
            end
            S_WAIT: begin
                priority if (r_kind == K_RPAR && r_top == OP_LPAR) begin
                    n_count = cnt_m1;
                    n_state = S_FIN;
                end else if (r_kind == K_RPAR || must_pop(r_code, r_top)) begin
                    if (can_emit) begin
                        em_req  = 1'b1;
                        em_sym  = code_char(r_top);
                        em_sv   = 1'b1;
                        n_count = cnt_m1;
                        n_state = S_EXEC;
                    end
                end else begin
                    do_push = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                priority if (!r_fin) begin
                    n_state = S_DONE;
                end else if (r_count != '0) begin
                    mem_re  = 1'b1;
                    n_state = S_FWAIT;
                end else if (r_pv) begin
                    n_state = S_DONE;
                end else if (can_emit) begin
                    em_req  = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_FWAIT: begin
                if (can_emit) begin
                    em_req  = 1'b1;
                    em_sym  = code_char(r_top);
                    em_sv   = 1'b1;
                    n_count = cnt_m1;
                    n_state = S_FIN;
                end
            end
            S_DONE: begin
                if (!r_pv) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_ov            = 1'b1;
                    n_out.sym       = r_pnd.sym;
                    n_out.sym_valid = r_pnd.sym_valid;
                    n_out.run_last  = 1'b1;
                    n_out.expr_end  = r_fin;
                    n_out.err       = r_fin ? r_err : r_pnd.err;
                    n_pv            = 1'b0;
                    if (r_fin) begin
                        n_err   = 1'b0;
                        n_count = '0;
                    end
                    n_state = S_IDLE;
                end
            end
        endcase

        if (do_push) begin
            if (r_count < DEPTH_C) begin
                mem_we  = 1'b1;
                n_count = r_count + CW'(1);
            end else begin
                n_err = 1'b1;
            end
        end

        if (em_req) begin
            if (r_pv) begin
                n_ov            = 1'b1;
                n_out.sym       = r_pnd.sym;
                n_out.sym_valid = r_pnd.sym_valid;
                n_out.run_last  = 1'b0;
                n_out.expr_end  = 1'b0;
                n_out.err       = r_pnd.err;
            end
            n_pnd.sym       = em_sym;
            n_pnd.sym_valid = em_sv;
            n_pnd.err       = r_err;
            n_pv            = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_err   <= 1'b0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_err   <= n_err;
            r_pv    <= n_pv;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_code <= n_code;
        r_sym  <= n_sym;
        r_fin  <= n_fin;
        r_pnd  <= n_pnd;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_stack_mem[mem_waddr] <= r_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_top <= r_stack_mem[mem_raddr];
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_ov;
    assign o_out_symbol   = r_out.sym;
    assign o_symbol_valid = r_out.sym_valid;
    assign o_run_last     = r_out.run_last;
    assign o_expr_end     = r_out.expr_end;
    assign o_error_flag   = r_out.err;

    `ITP_ASSERT(a_count_bound, r_count <= DEPTH_C, "Stack count exceeds the stack depth.")
    `ITP_ASSERT(a_idle_no_pend, (r_state != S_IDLE) || !r_pv, "Held result left over in idle.")
    `ITP_ASSERT(a_write_room, !mem_we || (r_count < DEPTH_C), "Stack write beyond the top.")
    `ITP_ASSERT(a_end_is_last, !(o_out_valid && o_expr_end) || o_run_last,
        "Expression end without the last-beat flag.")
    `ITP_ASSERT_NEXT(a_end_clears, (r_state == S_DONE) && r_fin && r_pv && out_free,
        (r_count == '0) && !r_err && o_out_valid && o_expr_end,
        "Expression end did not leave the stack and error clear.")

endmodule
